// ===== hdl/ess_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the eight-step sequencer.
// No dependencies; used by ess_ctrl, ess_datapath and eight_step_sequencer.
package ess_pkg;

    localparam int NUM_STEPS_DEF  = 8;
    localparam int PHASE_BITS_DEF = 24;

    localparam int ROW_W   = 32;
    localparam int NOTE_W  = 4;
    localparam int BTN_W   = 8;
    localparam int RND_W   = 8;
    localparam int CNT_W   = $clog2(RND_W);
    localparam int INC_W   = 24;
    localparam int REQ_W   = 4;
    localparam int DIR_W   = 2;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 2;

    localparam logic [NOTE_W-1:0] NOTE_MAX = 4'd11;

    localparam logic [DIR_W-1:0] DIR_UP       = 2'd0;
    localparam logic [DIR_W-1:0] DIR_PINGPONG = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RANDOM   = 2'd2;

    localparam logic [CFG_W-1:0] REG_ROW1 = 2'd0;
    localparam logic [CFG_W-1:0] REG_ROW2 = 2'd1;
    localparam logic [CFG_W-1:0] REG_ROW3 = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_COMMIT
    } ess_state_t;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_step;
        logic commit;
    } ess_cmd_t;

    typedef struct packed {
        logic rand_mode;
        logic div_last;
    } ess_stat_t;

    function automatic logic [NOTE_W-1:0] note_at(input logic [ROW_W-1:0] row,
                                                  input logic [IDX_W-1:0] idx);
        logic [ROW_W-1:0]  sh;
        logic [NOTE_W-1:0] v;
        sh = row >> {idx, 2'b00};
        v  = sh[NOTE_W-1:0];
        return (v > NOTE_MAX) ? NOTE_MAX : v;
    endfunction

endpackage

// ===== hdl/ess_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing controller: accepts a beat, runs the remainder unit when needed,
// commits into the output register. Depends on ess_pkg.
module ess_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  ess_pkg::ess_stat_t stat,
    output ess_pkg::ess_cmd_t  cmd
);

    ess_pkg::ess_state_t state_reg;
    ess_pkg::ess_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ess_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ess_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ess_pkg::S_DECIDE;
                end
            end
            ess_pkg::S_DECIDE:
            begin
                if (stat.rand_mode)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ess_pkg::S_DIV;
                end
                else
                begin
                    state_next = ess_pkg::S_COMMIT;
                end
            end
            ess_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ess_pkg::S_COMMIT;
                end
            end
            ess_pkg::S_COMMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ess_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ess_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("commit into an occupied output register");

    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ess_pkg::S_DECIDE))
        else $error("accepted beat not followed by decode");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ess_pkg::S_DIV && stat.div_last) |=> (state_reg == ess_pkg::S_COMMIT))
        else $error("remainder unit did not hand over to commit");

    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("output valid without commit");
`endif

endmodule

// ===== hdl/ess_datapath.sv =====
`timescale 1ns / 1ps
// Sequencer datapath: captured beat, sequencer state, remainder unit, row
// registers and output register. Depends on ess_pkg; driven by ess_ctrl.
module ess_datapath #(
    parameter int NUM_STEPS  = ess_pkg::NUM_STEPS_DEF,
    parameter int PHASE_BITS = ess_pkg::PHASE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ess_pkg::ess_cmd_t             cmd,
    output ess_pkg::ess_stat_t            stat,
    input  logic                          cfg_we,
    input  logic [ess_pkg::CFG_W-1:0]     cfg_index,
    input  logic [ess_pkg::ROW_W-1:0]     cfg_data,
    input  logic                          run_level,
    input  logic                          ext_clock_present,
    input  logic                          ext_clock_level,
    input  logic [ess_pkg::INC_W-1:0]     phase_step,
    input  logic                          reset_level,
    input  logic [ess_pkg::REQ_W-1:0]     step_count_request,
    input  logic [ess_pkg::DIR_W-1:0]     direction,
    input  logic [ess_pkg::BTN_W-1:0]     gate_buttons,
    input  logic [ess_pkg::RND_W-1:0]     random_byte,
    output logic [ess_pkg::IDX_W-1:0]     step_index,
    output logic                          running_flag,
    output logic [ess_pkg::BTN_W-1:0]     step_gates,
    output logic                          sum_gate,
    output logic [ess_pkg::NOTE_W-1:0]    row1_note,
    output logic [ess_pkg::NOTE_W-1:0]    row2_note,
    output logic [ess_pkg::NOTE_W-1:0]    row3_note,
    output logic                          advanced
);

    localparam int PW = $clog2(NUM_STEPS);
    localparam int AW = ($clog2(NUM_STEPS + 2) > ess_pkg::REQ_W) ?
                        $clog2(NUM_STEPS + 2) : ess_pkg::REQ_W;

    // captured beat
    logic                       cap_run_reg;
    logic                       cap_ext_p_reg;
    logic                       cap_ext_l_reg;
    logic [ess_pkg::INC_W-1:0]  cap_inc_reg;
    logic                       cap_rst_reg;
    logic [ess_pkg::REQ_W-1:0]  cap_req_reg;
    logic [ess_pkg::DIR_W-1:0]  cap_dir_reg;
    logic [ess_pkg::BTN_W-1:0]  cap_btn_reg;
    logic [ess_pkg::RND_W-1:0]  cap_rnd_reg;

    // sequencer state
    logic                       running_reg;
    logic                       running_next;
    logic [PHASE_BITS-1:0]      phase_acc_reg;
    logic [PHASE_BITS-1:0]      phase_acc_next;
    logic [PW-1:0]              step_pos_reg;
    logic [PW-1:0]              step_pos_next;
    logic                       going_down_reg;
    logic                       going_down_next;
    logic [NUM_STEPS-1:0]       gate_mask_reg;
    logic [NUM_STEPS-1:0]       gate_mask_next;
    logic                       last_run_reg;
    logic                       last_ext_reg;
    logic                       last_ext_next;
    logic                       last_rst_reg;
    logic [ess_pkg::BTN_W-1:0]  last_btn_reg;
    logic [ess_pkg::BTN_W-1:0]  btn_masked;

    logic [ess_pkg::ROW_W-1:0]  row1_reg;
    logic [ess_pkg::ROW_W-1:0]  row2_reg;
    logic [ess_pkg::ROW_W-1:0]  row3_reg;

    // remainder unit
    logic [AW-1:0]              rem_reg;
    logic [AW-1:0]              rem_next;
    logic [ess_pkg::CNT_W-1:0]  div_cnt_reg;
    logic [AW-1:0]              count;

    // output register
    logic [ess_pkg::IDX_W-1:0]  step_index_reg;
    logic                       running_flag_reg;
    logic [ess_pkg::BTN_W-1:0]  step_gates_reg;
    logic                       sum_gate_reg;
    logic [ess_pkg::NOTE_W-1:0] row1_note_reg;
    logic [ess_pkg::NOTE_W-1:0] row2_note_reg;
    logic [ess_pkg::NOTE_W-1:0] row3_note_reg;
    logic                       advanced_reg;

    logic [ess_pkg::IDX_W-1:0]  step_index_next;
    logic [ess_pkg::BTN_W-1:0]  step_gates_next;
    logic                       sum_gate_next;
    logic [ess_pkg::NOTE_W-1:0] row1_note_next;
    logic [ess_pkg::NOTE_W-1:0] row2_note_next;
    logic [ess_pkg::NOTE_W-1:0] row3_note_next;
    logic                       advanced_next;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_run_reg   <= run_level;
            cap_ext_p_reg <= ext_clock_present;
            cap_ext_l_reg <= ext_clock_level;
            cap_inc_reg   <= phase_step;
            cap_rst_reg   <= reset_level;
            cap_req_reg   <= step_count_request;
            cap_dir_reg   <= direction;
            cap_btn_reg   <= gate_buttons;
            cap_rnd_reg   <= random_byte;
        end
        if (cmd.div_start)
        begin
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.commit)
        begin
            step_index_reg   <= step_index_next;
            running_flag_reg <= running_next;
            step_gates_reg   <= step_gates_next;
            sum_gate_reg     <= sum_gate_next;
            row1_note_reg    <= row1_note_next;
            row2_note_reg    <= row2_note_next;
            row3_note_reg    <= row3_note_next;
            advanced_reg     <= advanced_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            phase_acc_reg  <= '0;
            step_pos_reg   <= '0;
            going_down_reg <= 1'b0;
            gate_mask_reg  <= '1;
            last_run_reg   <= 1'b0;
            last_ext_reg   <= 1'b0;
            last_rst_reg   <= 1'b0;
            last_btn_reg   <= '0;
            row1_reg       <= '0;
            row2_reg       <= '0;
            row3_reg       <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                running_reg    <= running_next;
                phase_acc_reg  <= phase_acc_next;
                step_pos_reg   <= step_pos_next;
                going_down_reg <= going_down_next;
                gate_mask_reg  <= gate_mask_next;
                last_run_reg   <= cap_run_reg;
                last_ext_reg   <= last_ext_next;
                last_rst_reg   <= cap_rst_reg;
                last_btn_reg   <= btn_masked;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    ess_pkg::REG_ROW1: row1_reg <= cfg_data;
                    ess_pkg::REG_ROW2: row2_reg <= cfg_data;
                    ess_pkg::REG_ROW3: row3_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // clamp step count to 1..NUM_STEPS
    always_comb
    begin
        logic [AW-1:0] req_ext;
        req_ext = AW'(cap_req_reg);
        if (req_ext == '0)
            count = AW'(1);
        else if (req_ext > AW'(NUM_STEPS))
            count = AW'(NUM_STEPS);
        else
            count = req_ext;
    end

    // one remainder bit per cycle, random byte taken MSB first
    always_comb
    begin
        logic [AW:0] trial;
        trial = {rem_reg, cap_rnd_reg[ess_pkg::CNT_W'(ess_pkg::RND_W - 1) - div_cnt_reg]};
        if (trial >= {1'b0, count})
            rem_next = AW'(trial - {1'b0, count});
        else
            rem_next = AW'(trial);
    end

    assign stat.rand_mode = (cap_dir_reg == ess_pkg::DIR_RANDOM);
    assign stat.div_last  = (div_cnt_reg == ess_pkg::CNT_W'(ess_pkg::RND_W - 1));

    always_comb
    begin
        logic [PHASE_BITS:0]       sum;
        logic                      rst_edge;
        logic                      clk_edge;
        logic                      gate_in;
        logic                      step_now;
        logic [AW-1:0]             pos;
        logic [AW-1:0]             p;
        logic [AW-1:0]             pos_new;
        logic                      enabled;
        logic                      in_row;
        logic [ess_pkg::BTN_W-1:0] rises;

        running_next    = running_reg ^ (cap_run_reg & ~last_run_reg);
        phase_acc_next  = phase_acc_reg;
        last_ext_next   = last_ext_reg;
        gate_in         = 1'b0;
        step_now        = 1'b0;
        sum             = {1'b0, phase_acc_reg} + {1'b0, PHASE_BITS'(cap_inc_reg)};
        clk_edge        = cap_ext_l_reg & ~last_ext_reg;

        if (running_next)
        begin
            if (cap_ext_p_reg)
            begin
                if (clk_edge)
                begin
                    phase_acc_next = '0;
                    step_now       = 1'b1;
                end
                last_ext_next = cap_ext_l_reg;
                gate_in       = cap_ext_l_reg;
            end
            else
            begin
                phase_acc_next = sum[PHASE_BITS-1:0];
                step_now       = sum[PHASE_BITS];
                gate_in        = ~sum[PHASE_BITS-1];
            end
        end

        rst_edge = cap_rst_reg & ~last_rst_reg;
        if (rst_edge)
        begin
            phase_acc_next = '0;
            step_now       = 1'b1;
        end

        // a restart moves from one past the last step
        pos             = rst_edge ? AW'(NUM_STEPS) : AW'(step_pos_reg);
        p               = pos;
        going_down_next = going_down_reg;
        if (step_now)
        begin
            if (cap_dir_reg == ess_pkg::DIR_PINGPONG)
            begin
                if (!going_down_reg)
                begin
                    p = pos + AW'(1);
                    if (p >= count)
                    begin
                        p               = (p >= AW'(2)) ? p - AW'(2) : '0;
                        going_down_next = 1'b1;
                    end
                end
                else if (pos == '0)
                begin
                    p               = AW'(1);
                    going_down_next = 1'b0;
                end
                else
                begin
                    p = pos - AW'(1);
                end
                if (p > count - AW'(1))
                    p = count - AW'(1);
            end
            else if (cap_dir_reg == ess_pkg::DIR_RANDOM)
            begin
                p = rem_reg;
            end
            else
            begin
                p = pos + AW'(1);
                if (p >= count)
                    p = '0;
            end
        end
        step_pos_next = PW'(p);

        btn_masked     = cap_btn_reg & ess_pkg::BTN_W'({NUM_STEPS{1'b1}});
        rises          = btn_masked & ~last_btn_reg;
        gate_mask_next = gate_mask_reg ^ NUM_STEPS'(rises);

        pos_new         = AW'(step_pos_next);
        enabled         = gate_mask_next[step_pos_next];
        in_row          = (pos_new[AW-1:ess_pkg::IDX_W] == '0);
        step_index_next = pos_new[ess_pkg::IDX_W-1:0];
        sum_gate_next   = gate_in & enabled;
        advanced_next   = step_now;
        step_gates_next = (running_next && gate_in && enabled && in_row) ?
                          (ess_pkg::BTN_W'(1) << step_index_next) : '0;
        row1_note_next  = in_row ? ess_pkg::note_at(row1_reg, step_index_next) : '0;
        row2_note_next  = in_row ? ess_pkg::note_at(row2_reg, step_index_next) : '0;
        row3_note_next  = in_row ? ess_pkg::note_at(row3_reg, step_index_next) : '0;
    end

    assign step_index   = step_index_reg;
    assign running_flag = running_flag_reg;
    assign step_gates   = step_gates_reg;
    assign sum_gate     = sum_gate_reg;
    assign row1_note    = row1_note_reg;
    assign row2_note    = row2_note_reg;
    assign row3_note    = row3_note_reg;
    assign advanced     = advanced_reg;

endmodule

// ===== hdl/eight_step_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the eight-step gate and note sequencer.
// Depends on ess_pkg, ess_ctrl and ess_datapath.
//
//  channel   handshake              payload
//  in        in_valid / in_stall    run_level .. random_byte, one tick per beat
//  out       out_valid / out_stall  step_index .. advanced, one result per beat
//  cfg       cfg_we                 cfg_index, cfg_data (row registers)
//
// A beat is accepted in S_IDLE, then passes S_DECIDE and is committed in S_COMMIT;
// in random mode the remainder unit runs in S_DIV between them, one random_byte bit
// per step. The next beat is accepted in the cycle after the commit.
// The next beat is accepted once the previous one has been committed to the
// output register; a stalled result holds there while the next beat computes.
// Reset (rst_n low) stops the sequencer, clears position and enables all steps.
module eight_step_sequencer #(
    parameter int NUM_STEPS  = ess_pkg::NUM_STEPS_DEF,
    parameter int PHASE_BITS = ess_pkg::PHASE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          run_level,
    input  logic                          ext_clock_present,
    input  logic                          ext_clock_level,
    input  logic [ess_pkg::INC_W-1:0]     phase_step,
    input  logic                          reset_level,
    input  logic [ess_pkg::REQ_W-1:0]     step_count_request,
    input  logic [ess_pkg::DIR_W-1:0]     direction,
    input  logic [ess_pkg::BTN_W-1:0]     gate_buttons,
    input  logic [ess_pkg::RND_W-1:0]     random_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ess_pkg::IDX_W-1:0]     step_index,
    output logic                          running_flag,
    output logic [ess_pkg::BTN_W-1:0]     step_gates,
    output logic                          sum_gate,
    output logic [ess_pkg::NOTE_W-1:0]    row1_note,
    output logic [ess_pkg::NOTE_W-1:0]    row2_note,
    output logic [ess_pkg::NOTE_W-1:0]    row3_note,
    output logic                          advanced,
    input  logic                          cfg_we,
    input  logic [ess_pkg::CFG_W-1:0]     cfg_index,
    input  logic [ess_pkg::ROW_W-1:0]     cfg_data
);

    ess_pkg::ess_cmd_t  cmd;
    ess_pkg::ess_stat_t stat;

    ess_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ess_datapath #(
        .NUM_STEPS  (NUM_STEPS),
        .PHASE_BITS (PHASE_BITS)
    ) u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .run_level          (run_level),
        .ext_clock_present  (ext_clock_present),
        .ext_clock_level    (ext_clock_level),
        .phase_step         (phase_step),
        .reset_level        (reset_level),
        .step_count_request (step_count_request),
        .direction          (direction),
        .gate_buttons       (gate_buttons),
        .random_byte        (random_byte),
        .step_index         (step_index),
        .running_flag       (running_flag),
        .step_gates         (step_gates),
        .sum_gate           (sum_gate),
        .row1_note          (row1_note),
        .row2_note          (row2_note),
        .row3_note          (row3_note),
        .advanced           (advanced)
    );

endmodule
